### rtl/cp15tra_pkg.sv
`default_nettype none

package cp15tra_pkg;

   // Configuration port
   localparam int CSR_ADDR_W = 4;

   localparam logic [1:0] CSR_CPU_MODEL = 2'd0;
   localparam logic [1:0] CSR_HAS_AUX   = 2'd1;
   localparam logic [1:0] CSR_HAS_V7    = 2'd2;
   localparam logic [1:0] CSR_HAS_V7_MP = 2'd3;

   // CPU model codes
   localparam logic [2:0] MODEL_V5     = 3'd0;
   localparam logic [2:0] MODEL_V6     = 3'd1;
   localparam logic [2:0] MODEL_V6R2   = 3'd2;
   localparam logic [2:0] MODEL_V6MP   = 3'd3;
   localparam logic [2:0] MODEL_V7A    = 3'd4;
   localparam logic [2:0] MODEL_V7MP   = 3'd5;
   localparam logic [2:0] MODEL_V7VE   = 3'd6;
   localparam logic [2:0] MODEL_OTHER  = 3'd7;

   // Cache maintenance request codes
   localparam logic [1:0] CACHE_NONE      = 2'd0;
   localparam logic [1:0] CACHE_CLEAN_INV = 2'd1;
   localparam logic [1:0] CACHE_CLEAN     = 2'd2;

   // Primary register numbers
   localparam logic [3:0] CRN_CTRL  = 4'd1;
   localparam logic [3:0] CRN_CACHE = 4'd7;
   localparam logic [3:0] CRN_LOCK  = 4'd9;
   localparam logic [3:0] CRN_IMPL  = 4'd15;

   // Secondary register numbers
   localparam logic [3:0] CRM_LOCKDOWN      = 4'd0;
   localparam logic [3:0] CRM_CLEAN_INV     = 4'd6;
   localparam logic [3:0] CRM_CLEAN         = 4'd10;
   localparam logic [3:0] CRM_CLEAN_INV_ALT = 4'd14;
   localparam logic [3:0] CRM_PMU_CTRL      = 4'd12;
   localparam logic [3:0] CRM_PMU_EVT       = 4'd13;
   localparam logic [3:0] CRM_PMU_USER      = 4'd14;

   // opc1 values
   localparam logic [2:0] OPC1_ZERO = 3'd0;
   localparam logic [2:0] OPC1_L2   = 3'd1;
   localparam logic [2:0] OPC1_CBAR = 3'd4;

   // opc2 values
   localparam logic [2:0] OPC2_AUX      = 3'd1;
   localparam logic [2:0] OPC2_SETWAY   = 3'd2;
   localparam logic [2:0] OPC2_DLOCK    = 3'd0;
   localparam logic [2:0] OPC2_ILOCK    = 3'd1;
   localparam logic [2:0] OPC2_PMCR     = 3'd0;
   localparam logic [2:0] OPC2_CNTENS   = 3'd1;
   localparam logic [2:0] OPC2_CNTENC   = 3'd2;
   localparam logic [2:0] OPC2_OVSR     = 3'd3;
   localparam logic [2:0] OPC2_SWINC    = 3'd4;
   localparam logic [2:0] OPC2_SELR     = 3'd5;
   localparam logic [2:0] OPC2_CCNT     = 3'd0;
   localparam logic [2:0] OPC2_EVTYPER  = 3'd1;
   localparam logic [2:0] OPC2_EVCNT    = 3'd2;
   localparam logic [2:0] OPC2_USEREN   = 3'd0;
   localparam logic [2:0] OPC2_INTENS   = 3'd1;
   localparam logic [2:0] OPC2_INTENC   = 3'd2;

   // Register values
   localparam logic [31:0] PMCR_WRITABLE = 32'h0000_0039;
   localparam logic [31:0] PMCR_RESET    = 32'h4100_0000;
   localparam logic [31:0] CBAR_V7MP     = 32'h1e00_0000;
   localparam logic [31:0] CBAR_V7VE     = 32'h2c00_0000;
   localparam logic [31:0] AUX_SMP_BIT   = 32'h0000_0040;
   localparam logic [31:0] AUX_V5        = 32'd1;
   localparam logic [31:0] AUX_V6        = 32'd7;
   localparam logic [31:0] AUX_V6MP      = 32'd1;
   localparam logic [31:0] AUX_V7A       = 32'd2;
   localparam int          EVT_W         = 8;

   typedef struct packed {
      logic        is_write;
      logic [3:0]  crn;
      logic [3:0]  crm;
      logic [2:0]  opc1;
      logic [2:0]  opc2;
      logic [31:0] wdata;
   } access_type;

   typedef struct packed {
      logic [2:0] cpu_model;
      logic       has_aux;
      logic       has_v7;
      logic       has_v7_mp;
   } cfg_type;

   typedef struct packed {
      logic        ok;
      logic [31:0] rdata;
      logic [1:0]  cache_op;
      logic        wr_dlock;
      logic        wr_ilock;
      logic        wr_pmcr;
      logic        set_cyc_en;
      logic        clr_cyc_en;
      logic        wr_evt;
      logic        wr_user;
      logic        set_irq_en;
      logic        clr_irq_en;
   } decode_type;

endpackage

`default_nettype wire

### rtl/cp15tra_decode.sv
`default_nettype none

module cp15tra_decode (
   input  cp15tra_pkg::access_type acc_i,
   input  cp15tra_pkg::cfg_type    cfg_i,
   input  logic [31:0]             dlock_i,
   input  logic [31:0]             ilock_i,
   output cp15tra_pkg::decode_type dec_o
);
   import cp15tra_pkg::*;

   logic is_v7_smp;

   assign is_v7_smp = (cfg_i.cpu_model == MODEL_V7MP) || (cfg_i.cpu_model == MODEL_V7VE);

   always_comb begin
      dec_o = '0;
      if (!acc_i.is_write) begin
         // register reads
         case (acc_i.crn)
            CRN_CTRL: begin
               if (acc_i.opc2 == OPC2_AUX && cfg_i.has_aux) begin
                  case (cfg_i.cpu_model)
                     MODEL_V5: begin
                        dec_o.ok    = 1'b1;
                        dec_o.rdata = AUX_V5;
                     end
                     MODEL_V6, MODEL_V6R2: begin
                        dec_o.ok    = 1'b1;
                        dec_o.rdata = AUX_V6;
                     end
                     MODEL_V6MP: begin
                        dec_o.ok    = 1'b1;
                        dec_o.rdata = AUX_V6MP;
                     end
                     MODEL_V7A: begin
                        dec_o.ok    = 1'b1;
                        dec_o.rdata = AUX_V7A;
                     end
                     MODEL_V7MP, MODEL_V7VE: begin
                        dec_o.ok    = 1'b1;
                        dec_o.rdata = cfg_i.has_v7_mp ? AUX_SMP_BIT : '0;
                     end
                     default: dec_o.ok = 1'b0;
                  endcase
               end
            end
            CRN_LOCK: begin
               if (acc_i.opc1 == OPC1_ZERO) begin
                  if (acc_i.opc2 == OPC2_DLOCK) begin
                     dec_o.ok    = 1'b1;
                     dec_o.rdata = dlock_i;
                  end else if (acc_i.opc2 == OPC2_ILOCK) begin
                     dec_o.ok    = 1'b1;
                     dec_o.rdata = ilock_i;
                  end
               end else if (acc_i.opc1 == OPC1_L2) begin
                  dec_o.ok = (acc_i.crm == CRM_LOCKDOWN);
               end
            end
            CRN_IMPL: begin
               if (acc_i.opc1 == OPC1_ZERO) begin
                  dec_o.ok = is_v7_smp;
               end else if (acc_i.opc1 == OPC1_CBAR) begin
                  if (cfg_i.cpu_model == MODEL_V7MP) begin
                     dec_o.ok    = 1'b1;
                     dec_o.rdata = CBAR_V7MP;
                  end else if (cfg_i.cpu_model == MODEL_V7VE) begin
                     dec_o.ok    = 1'b1;
                     dec_o.rdata = CBAR_V7VE;
                  end
               end
            end
            default: dec_o.ok = 1'b0;
         endcase
      end else begin
         // register writes
         case (acc_i.crn)
            CRN_CTRL: dec_o.ok = (acc_i.opc2 == OPC2_AUX) && cfg_i.has_aux;
            CRN_CACHE: begin
               if (acc_i.opc2 == OPC2_SETWAY) begin
                  if (acc_i.crm == CRM_CLEAN_INV || acc_i.crm == CRM_CLEAN_INV_ALT) begin
                     dec_o.ok       = 1'b1;
                     dec_o.cache_op = CACHE_CLEAN_INV;
                  end else if (acc_i.crm == CRM_CLEAN) begin
                     dec_o.ok       = 1'b1;
                     dec_o.cache_op = CACHE_CLEAN;
                  end
               end
            end
            CRN_LOCK: begin
               case (acc_i.crm)
                  CRM_LOCKDOWN: begin
                     if (acc_i.opc1 == OPC1_ZERO) begin
                        dec_o.wr_dlock = (acc_i.opc2 == OPC2_DLOCK);
                        dec_o.wr_ilock = (acc_i.opc2 == OPC2_ILOCK);
                        dec_o.ok       = dec_o.wr_dlock || dec_o.wr_ilock;
                     end else begin
                        dec_o.ok = (acc_i.opc1 == OPC1_L2);
                     end
                  end
                  CRM_PMU_CTRL: begin
                     if (cfg_i.has_v7) begin
                        case (acc_i.opc2)
                           OPC2_PMCR: begin
                              dec_o.ok      = 1'b1;
                              dec_o.wr_pmcr = 1'b1;
                           end
                           OPC2_CNTENS: begin
                              dec_o.ok         = 1'b1;
                              dec_o.set_cyc_en = 1'b1;
                           end
                           OPC2_CNTENC: begin
                              dec_o.ok         = 1'b1;
                              dec_o.clr_cyc_en = 1'b1;
                           end
                           OPC2_OVSR, OPC2_SWINC, OPC2_SELR: dec_o.ok = 1'b1;
                           default: dec_o.ok = 1'b0;
                        endcase
                     end
                  end
                  CRM_PMU_EVT: begin
                     if (cfg_i.has_v7) begin
                        case (acc_i.opc2)
                           OPC2_CCNT, OPC2_EVCNT: dec_o.ok = 1'b1;
                           OPC2_EVTYPER: begin
                              dec_o.ok     = 1'b1;
                              dec_o.wr_evt = 1'b1;
                           end
                           default: dec_o.ok = 1'b0;
                        endcase
                     end
                  end
                  CRM_PMU_USER: begin
                     if (cfg_i.has_v7) begin
                        // every opc2 is accepted here
                        dec_o.ok         = 1'b1;
                        dec_o.wr_user    = (acc_i.opc2 == OPC2_USEREN);
                        dec_o.set_irq_en = (acc_i.opc2 == OPC2_INTENS);
                        dec_o.clr_irq_en = (acc_i.opc2 == OPC2_INTENC);
                     end
                  end
                  default: dec_o.ok = 1'b0;
               endcase
            end
            CRN_IMPL: dec_o.ok = (acc_i.opc1 == OPC1_ZERO) && is_v7_smp;
            default: dec_o.ok = 1'b0;
         endcase
      end
   end

endmodule

`default_nettype wire

### rtl/cp15_trapped_register_access.sv
`default_nettype none

// Trapped system-control coprocessor access decoder.
// Request side: a command transfer happens on the rising edge where start is
// high and busy is low. It carries read/write, CRn, CRm, opc1, opc2 and the
// write data. busy is low except while reset is held, so one transfer can be
// taken on every clock edge.
// Response side: rsp_valid rises once the request has passed the request
// register and then the response register, and stays high for exactly one
// cycle with ok, read data and any set/way cache request.
// The receiver cannot stall; each response is a single-cycle strobe.
// The performance-monitor state (PMCR, cycle count/irq enable, event type,
// user enable) is shown on the rsp_ debug ports as it stands after the step.
// A request goes through the request register, then decode/update into the
// response register.
// Throughput: 1 transfer per cycle outside reset; decode is combinational.
// Configuration: APB registers at 0x0 cpu_model, 0x4 has_aux_control,
// 0x8 has_v7, 0xC has_v7_mp; write only while no request is in flight.
// Reset: synchronous; configuration returns to its defaults, lockdowns and
// monitor state clear, PMCR returns to its implementer value.
module cp15_trapped_register_access (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        start,
   output logic        busy,
   input  logic        req_type,
   input  logic [3:0]  req_crn,
   input  logic [3:0]  req_crm,
   input  logic [2:0]  req_opc1,
   input  logic [2:0]  req_opc2,
   input  logic [31:0] req_wdata,
   // response channel
   output logic        rsp_valid,
   output logic        rsp_ok,
   output logic [31:0] rsp_rdata,
   output logic [1:0]  rsp_cache_op,
   output logic [31:0] rsp_set_way_operand,
   output logic [31:0] rsp_pmcr_now,
   output logic        rsp_cycle_count_enabled,
   output logic        rsp_cycle_irq_enabled,
   output logic [7:0]  rsp_event_type_now,
   output logic        rsp_user_access_enabled,
   // configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [cp15tra_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import cp15tra_pkg::*;

   // configuration registers
   cfg_type     cfg_ff;
   logic        csr_wr;

   // request register
   logic        req_valid_ff;
   access_type  req_ff;
   logic        req_accept;

   // architectural state
   logic [31:0] dlock_ff;
   logic [31:0] ilock_ff;
   logic [31:0] pmcr_ff;
   logic        cyc_en_ff;
   logic        irq_en_ff;
   logic [EVT_W-1:0] evt_ff;
   logic        user_en_ff;

   logic [31:0] pmcr_in;
   logic        cyc_en_in;
   logic        irq_en_in;
   logic        upd;
   logic        bit31;

   // response register
   logic        rsp_valid_ff;
   logic        rsp_ok_ff;
   logic [31:0] rsp_rdata_ff;
   logic [1:0]  rsp_cache_op_ff;
   logic [31:0] rsp_operand_ff;

   decode_type  dec;

   // ---------------- configuration port ----------------
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cpu_model <= MODEL_V7VE;
         cfg_ff.has_aux   <= 1'b1;
         cfg_ff.has_v7    <= 1'b1;
         cfg_ff.has_v7_mp <= 1'b1;
      end else if (csr_wr) begin
         case (paddr[3:2])
            CSR_CPU_MODEL: cfg_ff.cpu_model <= pwdata[2:0];
            CSR_HAS_AUX:   cfg_ff.has_aux   <= pwdata[0];
            CSR_HAS_V7:    cfg_ff.has_v7    <= pwdata[0];
            CSR_HAS_V7_MP: cfg_ff.has_v7_mp <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         CSR_CPU_MODEL: prdata = {29'd0, cfg_ff.cpu_model};
         CSR_HAS_AUX:   prdata = {31'd0, cfg_ff.has_aux};
         CSR_HAS_V7:    prdata = {31'd0, cfg_ff.has_v7};
         CSR_HAS_V7_MP: prdata = {31'd0, cfg_ff.has_v7_mp};
         default:       prdata = '0;
      endcase
   end

   // ---------------- request capture ----------------
   // nothing is taken while reset is held
   assign busy       = reset;
   assign req_accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_ff.is_write <= req_type;
         req_ff.crn      <= req_crn;
         req_ff.crm      <= req_crm;
         req_ff.opc1     <= req_opc1;
         req_ff.opc2     <= req_opc2;
         req_ff.wdata    <= req_wdata;
      end
   end

   // ---------------- decode ----------------
   cp15tra_decode u_decode (
      .acc_i   (req_ff),
      .cfg_i   (cfg_ff),
      .dlock_i (dlock_ff),
      .ilock_i (ilock_ff),
      .dec_o   (dec)
   );

   // ---------------- state update ----------------
   // enable set/clear registers only act on bit 31 of the written data
   assign upd   = req_valid_ff;
   assign bit31 = req_ff.wdata[31];

   always_comb begin
      pmcr_in   = pmcr_ff;
      cyc_en_in = cyc_en_ff;
      irq_en_in = irq_en_ff;
      if (dec.wr_pmcr) begin
         pmcr_in = (pmcr_ff & ~PMCR_WRITABLE) | (req_ff.wdata & PMCR_WRITABLE);
      end
      if (dec.set_cyc_en && bit31) begin
         cyc_en_in = 1'b1;
      end
      if (dec.clr_cyc_en && bit31) begin
         cyc_en_in = 1'b0;
      end
      if (dec.set_irq_en && bit31) begin
         irq_en_in = 1'b1;
      end
      if (dec.clr_irq_en && bit31) begin
         irq_en_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dlock_ff   <= '0;
         ilock_ff   <= '0;
         pmcr_ff    <= PMCR_RESET;
         cyc_en_ff  <= 1'b0;
         irq_en_ff  <= 1'b0;
         evt_ff     <= '0;
         user_en_ff <= 1'b0;
      end else if (upd) begin
         if (dec.wr_dlock) begin
            dlock_ff <= req_ff.wdata;
         end
         if (dec.wr_ilock) begin
            ilock_ff <= req_ff.wdata;
         end
         if (dec.wr_evt) begin
            evt_ff <= req_ff.wdata[EVT_W-1:0];
         end
         if (dec.wr_user) begin
            user_en_ff <= req_ff.wdata[0];
         end
         pmcr_ff   <= pmcr_in;
         cyc_en_ff <= cyc_en_in;
         irq_en_ff <= irq_en_in;
      end
   end

   // ---------------- response register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff    <= 1'b0;
         rsp_cache_op_ff <= CACHE_NONE;
      end else begin
         rsp_valid_ff    <= req_valid_ff;
         rsp_cache_op_ff <= req_valid_ff ? dec.cache_op : CACHE_NONE;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ok_ff      <= dec.ok;
      rsp_rdata_ff   <= dec.rdata;
      rsp_operand_ff <= (dec.cache_op != CACHE_NONE) ? req_ff.wdata : '0;
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_ok                  = rsp_ok_ff;
   assign rsp_rdata               = rsp_rdata_ff;
   assign rsp_cache_op            = rsp_cache_op_ff;
   assign rsp_set_way_operand     = rsp_operand_ff;
   // state registers update on the same edge as the response, so they show
   // the post-step value for the whole strobe cycle
   assign rsp_pmcr_now            = pmcr_ff;
   assign rsp_cycle_count_enabled = cyc_en_ff;
   assign rsp_cycle_irq_enabled   = irq_en_ff;
   assign rsp_event_type_now      = evt_ff;
   assign rsp_user_access_enabled = user_en_ff;

`ifndef SYNTHESIS
   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(req_valid_ff))
      else $error("response without a request in flight");

   a_cache_op_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_cache_op_ff != CACHE_NONE) |-> (rsp_ok_ff && rsp_valid_ff
         && rsp_cache_op_ff != 2'd3))
      else $error("cache request on an unhandled access");

   a_rdata_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_rdata_ff != '0) |-> rsp_ok_ff)
      else $error("read data on an invalid access");

   a_pmcr_fixed: assert property (@(posedge clock) disable iff (reset)
      (pmcr_ff & ~PMCR_WRITABLE) == PMCR_RESET)
      else $error("read-only PMCR bits changed");
`endif

endmodule

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
   import cp15tra_pkg::*;

   // Requests are command transfers (start/busy); responses are one-cycle
   // strobes on rsp_valid that cannot be held off. Every accepted request is
   // run through a local model of the decoder at the moment of its transfer,
   // and the expected response is queued. Each response strobe is compared,
   // field by field, against the oldest queued expectation.

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int PHASES         = 13;
   localparam int PHASE_ITEMS    = 100;
   localparam int DIRECTED_ROWS  = 25;

   typedef struct packed {
      logic        ok;
      logic [31:0] rdata;
      logic [1:0]  cache_op;
      logic [31:0] set_way_operand;
      logic [31:0] pmcr_now;
      logic        cycle_count_enabled;
      logic        cycle_irq_enabled;
      logic [7:0]  event_type_now;
      logic        user_access_enabled;
   } access_result_type;

   // One directed row: the access and, where it is obvious, the ok flag and
   // read data it must give. Other fields always come from the local model.
   typedef struct packed {
      access_type  acc;
      logic        pinned;
      logic        ok;
      logic [31:0] rdata;
   } directed_row_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_type;
   logic [3:0]  req_crn;
   logic [3:0]  req_crm;
   logic [2:0]  req_opc1;
   logic [2:0]  req_opc2;
   logic [31:0] req_wdata;
   logic        rsp_valid;
   logic        rsp_ok;
   logic [31:0] rsp_rdata;
   logic [1:0]  rsp_cache_op;
   logic [31:0] rsp_set_way_operand;
   logic [31:0] rsp_pmcr_now;
   logic        rsp_cycle_count_enabled;
   logic        rsp_cycle_irq_enabled;
   logic [7:0]  rsp_event_type_now;
   logic        rsp_user_access_enabled;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   cp15_trapped_register_access i_dut (
      .clock                   (clock),
      .reset                   (reset),
      .start                   (start),
      .busy                    (busy),
      .req_type                (req_type),
      .req_crn                 (req_crn),
      .req_crm                 (req_crm),
      .req_opc1                (req_opc1),
      .req_opc2                (req_opc2),
      .req_wdata               (req_wdata),
      .rsp_valid               (rsp_valid),
      .rsp_ok                  (rsp_ok),
      .rsp_rdata               (rsp_rdata),
      .rsp_cache_op            (rsp_cache_op),
      .rsp_set_way_operand     (rsp_set_way_operand),
      .rsp_pmcr_now            (rsp_pmcr_now),
      .rsp_cycle_count_enabled (rsp_cycle_count_enabled),
      .rsp_cycle_irq_enabled   (rsp_cycle_irq_enabled),
      .rsp_event_type_now      (rsp_event_type_now),
      .rsp_user_access_enabled (rsp_user_access_enabled),
      .psel                    (psel),
      .penable                 (penable),
      .pwrite                  (pwrite),
      .paddr                   (paddr),
      .pwdata                  (pwdata),
      .prdata                  (prdata),
      .pready                  (pready)
   );

   // Model copy of configuration and register state, reset values.
   cfg_type     cfg_now     = '{cpu_model: MODEL_V7VE, has_aux: 1'b1,
                                has_v7: 1'b1, has_v7_mp: 1'b1};
   logic [31:0] dlock_q     = '0;
   logic [31:0] ilock_q     = '0;
   logic [31:0] pmcr_q      = PMCR_RESET;
   logic        cyc_en_q    = 1'b0;
   logic        cyc_irq_q   = 1'b0;
   logic [7:0]  evt_sel_q   = '0;
   logic        user_en_q   = 1'b0;

   access_result_type pending_results[$];
   int             fail_count = 0;
   int             quiet_cycles = 0;
   bit             no_gaps = 1'b0;

   // Pinned expectation for the request currently on the bus.
   logic        pin_valid = 1'b0;
   logic        pin_ok    = 1'b0;
   logic [31:0] pin_rdata = '0;

   directed_row_type directed_rows [DIRECTED_ROWS];

   // Decode one access against the model state and advance that state.
   function automatic access_result_type predict_access(input access_type a);
      access_result_type r;
      logic           v7_model;
      r        = '0;
      v7_model = (cfg_now.cpu_model == MODEL_V7MP) || (cfg_now.cpu_model == MODEL_V7VE);
      if (!a.is_write) begin
         case (a.crn)
            CRN_CTRL: begin
               if (a.opc2 == OPC2_AUX && cfg_now.has_aux) begin
                  r.ok = 1'b1;
                  case (cfg_now.cpu_model)
                     MODEL_V5:               r.rdata = AUX_V5;
                     MODEL_V6, MODEL_V6R2:   r.rdata = AUX_V6;
                     MODEL_V6MP:             r.rdata = AUX_V6MP;
                     MODEL_V7A:              r.rdata = AUX_V7A;
                     MODEL_V7MP, MODEL_V7VE: r.rdata = cfg_now.has_v7_mp ? AUX_SMP_BIT : '0;
                     default:                r.ok = 1'b0;
                  endcase
               end
            end
            CRN_LOCK: begin
               if (a.opc1 == OPC1_ZERO) begin
                  if (a.opc2 == OPC2_DLOCK) begin
                     r.ok    = 1'b1;
                     r.rdata = dlock_q;
                  end else if (a.opc2 == OPC2_ILOCK) begin
                     r.ok    = 1'b1;
                     r.rdata = ilock_q;
                  end
               end else if (a.opc1 == OPC1_L2) begin
                  r.ok = (a.crm == CRM_LOCKDOWN);
               end
            end
            CRN_IMPL: begin
               if (a.opc1 == OPC1_ZERO) begin
                  r.ok = v7_model;
               end else if (a.opc1 == OPC1_CBAR) begin
                  if (cfg_now.cpu_model == MODEL_V7MP) begin
                     r.ok    = 1'b1;
                     r.rdata = CBAR_V7MP;
                  end else if (cfg_now.cpu_model == MODEL_V7VE) begin
                     r.ok    = 1'b1;
                     r.rdata = CBAR_V7VE;
                  end
               end
            end
            default: ;
         endcase
      end else begin
         case (a.crn)
            CRN_CTRL: r.ok = (a.opc2 == OPC2_AUX) && cfg_now.has_aux;
            CRN_CACHE: begin
               if (a.opc2 == OPC2_SETWAY) begin
                  if (a.crm == CRM_CLEAN_INV || a.crm == CRM_CLEAN_INV_ALT) begin
                     r.ok       = 1'b1;
                     r.cache_op = CACHE_CLEAN_INV;
                  end else if (a.crm == CRM_CLEAN) begin
                     r.ok       = 1'b1;
                     r.cache_op = CACHE_CLEAN;
                  end
               end
            end
            CRN_LOCK: begin
               case (a.crm)
                  CRM_LOCKDOWN: begin
                     if (a.opc1 == OPC1_ZERO) begin
                        if (a.opc2 == OPC2_DLOCK) begin
                           r.ok    = 1'b1;
                           dlock_q = a.wdata;
                        end else if (a.opc2 == OPC2_ILOCK) begin
                           r.ok    = 1'b1;
                           ilock_q = a.wdata;
                        end
                     end else begin
                        r.ok = (a.opc1 == OPC1_L2);
                     end
                  end
                  CRM_PMU_CTRL: begin
                     if (cfg_now.has_v7) begin
                        r.ok = 1'b1;
                        case (a.opc2)
                           OPC2_PMCR:   pmcr_q = (pmcr_q & ~PMCR_WRITABLE)
                                                 | (a.wdata & PMCR_WRITABLE);
                           OPC2_CNTENS: if (a.wdata[31]) cyc_en_q = 1'b1;
                           OPC2_CNTENC: if (a.wdata[31]) cyc_en_q = 1'b0;
                           OPC2_OVSR, OPC2_SWINC, OPC2_SELR: ;
                           default:     r.ok = 1'b0;
                        endcase
                     end
                  end
                  CRM_PMU_EVT: begin
                     if (cfg_now.has_v7) begin
                        r.ok = 1'b1;
                        case (a.opc2)
                           OPC2_CCNT, OPC2_EVCNT: ;
                           OPC2_EVTYPER:          evt_sel_q = a.wdata[EVT_W-1:0];
                           default:               r.ok = 1'b0;
                        endcase
                     end
                  end
                  CRM_PMU_USER: begin
                     // every opc2 is taken here; the unnamed ones are no-ops
                     if (cfg_now.has_v7) begin
                        r.ok = 1'b1;
                        case (a.opc2)
                           OPC2_USEREN: user_en_q = a.wdata[0];
                           OPC2_INTENS: if (a.wdata[31]) cyc_irq_q = 1'b1;
                           OPC2_INTENC: if (a.wdata[31]) cyc_irq_q = 1'b0;
                           default: ;
                        endcase
                     end
                  end
                  default: ;
               endcase
            end
            CRN_IMPL: r.ok = (a.opc1 == OPC1_ZERO) && v7_model;
            default: ;
         endcase
      end
      r.set_way_operand     = (r.cache_op != CACHE_NONE) ? a.wdata : '0;
      r.pmcr_now            = pmcr_q;
      r.cycle_count_enabled = cyc_en_q;
      r.cycle_irq_enabled   = cyc_irq_q;
      r.event_type_now      = evt_sel_q;
      r.user_access_enabled = user_en_q;
      return r;
   endfunction

   // Mostly accesses that hit a decoded register with random don't-care
   // fields; a third are fully random selectors, which are mostly invalid.
   function automatic access_type random_access();
      access_type a;
      a.is_write = 1'($urandom);
      a.crn      = 4'($urandom);
      a.crm      = 4'($urandom);
      a.opc1     = 3'($urandom);
      a.opc2     = 3'($urandom);
      case ($urandom_range(0, 3))
         0:       a.wdata = '0;
         1:       a.wdata = '1;
         default: a.wdata = $urandom;
      endcase
      case ($urandom_range(0, 11))
         0: begin
            a.crn  = CRN_CTRL;
            a.opc2 = OPC2_AUX;
         end
         1: begin
            a.crn  = CRN_LOCK;
            a.crm  = ($urandom_range(0, 3) == 0) ? a.crm : CRM_LOCKDOWN;
            a.opc1 = OPC1_ZERO;
            a.opc2 = $urandom_range(0, 1) ? OPC2_DLOCK : OPC2_ILOCK;
         end
         2: begin
            a.crn  = CRN_LOCK;
            a.crm  = ($urandom_range(0, 1) == 0) ? a.crm : CRM_LOCKDOWN;
            a.opc1 = OPC1_L2;
         end
         3: begin
            a.crn      = CRN_CACHE;
            a.is_write = ($urandom_range(0, 3) != 0);
            a.opc2     = OPC2_SETWAY;
            case ($urandom_range(0, 2))
               0:       a.crm = CRM_CLEAN_INV;
               1:       a.crm = CRM_CLEAN_INV_ALT;
               default: a.crm = CRM_CLEAN;
            endcase
         end
         4, 5, 6: begin
            a.crn      = CRN_LOCK;
            a.is_write = ($urandom_range(0, 7) != 0);
            case ($urandom_range(0, 2))
               0:       a.crm = CRM_PMU_CTRL;
               1:       a.crm = CRM_PMU_EVT;
               default: a.crm = CRM_PMU_USER;
            endcase
         end
         7: begin
            a.crn  = CRN_IMPL;
            a.opc1 = $urandom_range(0, 1) ? OPC1_ZERO : OPC1_CBAR;
         end
         default: ;
      endcase
      return a;
   endfunction

   task automatic flag_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      fail_count++;
      if (fail_count <= 10)
         $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
   endtask

   // One command transfer. Entered and left at a falling edge.
   task automatic send_access(input access_type a, input logic pinned,
                              input logic p_ok, input logic [31:0] p_rdata);
      int unsigned gap;
      if ($urandom_range(0, 39) == 0)
         no_gaps = ~no_gaps;
      gap = no_gaps ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_type  = a.is_write;
      req_crn   = a.crn;
      req_crm   = a.crm;
      req_opc1  = a.opc1;
      req_opc2  = a.opc2;
      req_wdata = a.wdata;
      pin_valid = pinned;
      pin_ok    = p_ok;
      pin_rdata = p_rdata;
      start     = 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // APB write, setup then access phase. Entered and left at a falling edge.
   task automatic csr_write(input logic [1:0] idx, input logic [31:0] val);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {idx, 2'b00};
      pwdata  = val;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   // Let the decoder drain, then rewrite every configuration register.
   task automatic apply_settings(input cfg_type c);
      start = 1'b0;
      while (pending_results.size() != 0)
         @(negedge clock);
      csr_write(CSR_CPU_MODEL, 32'(c.cpu_model));
      csr_write(CSR_HAS_AUX,   32'(c.has_aux));
      csr_write(CSR_HAS_V7,    32'(c.has_v7));
      csr_write(CSR_HAS_V7_MP, 32'(c.has_v7_mp));
      cfg_now = c;
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Response check, then request capture. A response always belongs to a
   // transfer that has already passed the request register, so the order within
   // this block is what keeps the queue coherent.
   always @(posedge clock) begin : monitor
      access_result_type want;
      access_type     a;
      if (!reset) begin
         if (rsp_valid) begin
            if (pending_results.size() == 0) begin
               flag_mismatch("unexpected response, ok", '0, 32'(rsp_ok));
            end else begin
               want = pending_results.pop_front();
               if (rsp_ok !== want.ok)
                  flag_mismatch("ok", 32'(want.ok), 32'(rsp_ok));
               if (rsp_rdata !== want.rdata)
                  flag_mismatch("rdata", want.rdata, rsp_rdata);
               if (rsp_cache_op !== want.cache_op)
                  flag_mismatch("cache_op", 32'(want.cache_op), 32'(rsp_cache_op));
               if (rsp_set_way_operand !== want.set_way_operand)
                  flag_mismatch("set_way_operand", want.set_way_operand,
                                rsp_set_way_operand);
               if (rsp_pmcr_now !== want.pmcr_now)
                  flag_mismatch("pmcr_now", want.pmcr_now, rsp_pmcr_now);
               if (rsp_cycle_count_enabled !== want.cycle_count_enabled)
                  flag_mismatch("cycle_count_enabled", 32'(want.cycle_count_enabled),
                                32'(rsp_cycle_count_enabled));
               if (rsp_cycle_irq_enabled !== want.cycle_irq_enabled)
                  flag_mismatch("cycle_irq_enabled", 32'(want.cycle_irq_enabled),
                                32'(rsp_cycle_irq_enabled));
               if (rsp_event_type_now !== want.event_type_now)
                  flag_mismatch("event_type_now", 32'(want.event_type_now),
                                32'(rsp_event_type_now));
               if (rsp_user_access_enabled !== want.user_access_enabled)
                  flag_mismatch("user_access_enabled", 32'(want.user_access_enabled),
                                32'(rsp_user_access_enabled));
            end
         end
         if (start && !busy) begin
            a = '{is_write: req_type, crn: req_crn, crm: req_crm, opc1: req_opc1,
                  opc2: req_opc2, wdata: req_wdata};
            want = predict_access(a);
            if (pin_valid) begin
               want.ok    = pin_ok;
               want.rdata = pin_rdata;
            end
            pending_results.push_back(want);
         end
      end
      // watchdog: only a request transfer counts as progress
      if (start && !busy)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      cfg_type c;
      start     = 1'b0;
      req_type  = 1'b0;
      req_crn   = '0;
      req_crm   = '0;
      req_opc1  = '0;
      req_opc2  = '0;
      req_wdata = '0;
      psel      = 1'b0;
      penable   = 1'b0;
      pwrite    = 1'b0;
      paddr     = '0;
      pwdata    = '0;
      reset     = 1'b1;

      // Directed rows run under the reset configuration (newest model, all
      // features on). Pinned rows carry the obvious ok/rdata by hand.
      directed_rows = '{
         // aux control with SMP bit set
         '{'{1'b0, CRN_CTRL, 4'd0, OPC1_ZERO, OPC2_AUX, 32'h0}, 1'b1, 1'b1, AUX_SMP_BIT},
         // lockdowns read zero out of reset
         '{'{1'b0, CRN_LOCK, CRM_LOCKDOWN, OPC1_ZERO, OPC2_DLOCK, 32'h0}, 1'b1, 1'b1, 32'h0},
         '{'{1'b0, CRN_LOCK, CRM_LOCKDOWN, OPC1_ZERO, OPC2_ILOCK, 32'h0}, 1'b1, 1'b1, 32'h0},
         '{'{1'b1, CRN_LOCK, CRM_LOCKDOWN, OPC1_ZERO, OPC2_DLOCK, 32'hffff_ffff},
           1'b1, 1'b1, 32'h0},
         // CRm not decoded on the lockdown read
         '{'{1'b0, CRN_LOCK, 4'd15, OPC1_ZERO, OPC2_DLOCK, 32'h0}, 1'b0, 1'b0, 32'h0},
         '{'{1'b1, CRN_LOCK, CRM_LOCKDOWN, OPC1_ZERO, OPC2_ILOCK, 32'ha5a5_5a5a},
           1'b0, 1'b0, 32'h0},
         '{'{1'b0, CRN_LOCK, CRM_LOCKDOWN, OPC1_ZERO, OPC2_ILOCK, 32'h0}, 1'b0, 1'b0, 32'h0},
         // L2 lockdown: zero with CRm 0, invalid otherwise
         '{'{1'b0, CRN_LOCK, CRM_LOCKDOWN, OPC1_L2, 3'd7, 32'h0}, 1'b1, 1'b1, 32'h0},
         '{'{1'b0, CRN_LOCK, 4'd5, OPC1_L2, 3'd0, 32'h0}, 1'b1, 1'b0, 32'h0},
         // power control and config base address
         '{'{1'b0, CRN_IMPL, 4'd15, OPC1_ZERO, 3'd7, 32'h0}, 1'b1, 1'b1, 32'h0},
         '{'{1'b0, CRN_IMPL, 4'd0, OPC1_CBAR, 3'd0, 32'h0}, 1'b1, 1'b1, CBAR_V7VE},
         // set/way maintenance, all three encodings, then a wrong opc2
         '{'{1'b1, CRN_CACHE, CRM_CLEAN_INV, 3'd7, OPC2_SETWAY, 32'hffff_ffff},
           1'b0, 1'b0, 32'h0},
         '{'{1'b1, CRN_CACHE, CRM_CLEAN_INV_ALT, 3'd0, OPC2_SETWAY, 32'h1234_5678},
           1'b0, 1'b0, 32'h0},
         '{'{1'b1, CRN_CACHE, CRM_CLEAN, 3'd0, OPC2_SETWAY, 32'h0}, 1'b0, 1'b0, 32'h0},
         '{'{1'b1, CRN_CACHE, CRM_CLEAN_INV, 3'd0, 3'd3, 32'hffff_ffff}, 1'b1, 1'b0, 32'h0},
         // monitor updates
         '{'{1'b1, CRN_LOCK, CRM_PMU_CTRL, 3'd0, OPC2_PMCR, 32'hffff_ffff}, 1'b0, 1'b0, 32'h0},
         '{'{1'b1, CRN_LOCK, CRM_PMU_CTRL, 3'd0, OPC2_CNTENS, 32'h8000_0000},
           1'b0, 1'b0, 32'h0},
         // clear without bit 31 leaves the enable alone
         '{'{1'b1, CRN_LOCK, CRM_PMU_CTRL, 3'd0, OPC2_CNTENC, 32'h7fff_ffff},
           1'b0, 1'b0, 32'h0},
         '{'{1'b1, CRN_LOCK, CRM_PMU_EVT, 3'd0, OPC2_EVTYPER, 32'hffff_ffff},
           1'b0, 1'b0, 32'h0},
         '{'{1'b1, CRN_LOCK, CRM_PMU_USER, 3'd0, OPC2_USEREN, 32'h1}, 1'b0, 1'b0, 32'h0},
         '{'{1'b1, CRN_LOCK, CRM_PMU_USER, 3'd0, OPC2_INTENS, 32'hffff_ffff},
           1'b0, 1'b0, 32'h0},
         // CRm 14 high opc2 writes are taken and ignored
         '{'{1'b1, CRN_LOCK, CRM_PMU_USER, 3'd0, 3'd7, 32'h0}, 1'b1, 1'b1, 32'h0},
         // CRm 12 opc2 6 is not a register
         '{'{1'b1, CRN_LOCK, CRM_PMU_CTRL, 3'd0, 3'd6, 32'h0}, 1'b1, 1'b0, 32'h0},
         // unlisted CRn, then a CRn 15 write
         '{'{1'b0, 4'd0, 4'd0, 3'd0, 3'd0, 32'h0}, 1'b1, 1'b0, 32'h0},
         '{'{1'b1, CRN_IMPL, 4'd0, OPC1_ZERO, 3'd0, 32'hffff_ffff}, 1'b1, 1'b1, 32'h0}
      };

      repeat (11) @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i])
         send_access(directed_rows[i].acc, directed_rows[i].pinned,
                     directed_rows[i].ok, directed_rows[i].rdata);

      // Random phases: each model in turn, then the all-off and all-on
      // feature extremes, then random settings.
      for (int p = 0; p < PHASES; p++) begin
         c.cpu_model = (p < 8) ? 3'(p) : 3'($urandom_range(0, 7));
         if (p == 8)
            {c.has_aux, c.has_v7, c.has_v7_mp} = 3'b000;
         else if (p == 9)
            {c.has_aux, c.has_v7, c.has_v7_mp} = 3'b111;
         else
            {c.has_aux, c.has_v7, c.has_v7_mp} = 3'($urandom);
         apply_settings(c);
         repeat (PHASE_ITEMS)
            send_access(random_access(), 1'b0, 1'b0, 32'h0);
      end

      start = 1'b0;
      while (pending_results.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);

      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

### sim.f
rtl/cp15tra_pkg.sv
rtl/cp15tra_decode.sv
rtl/cp15_trapped_register_access.sv
tb/sv/tb.sv
